// File: design/truncated_time_of_day_rebuilder_defines.svh
// assertion macros shared by the time of day rebuilder modules
`ifndef TRUNCATED_TIME_OF_DAY_REBUILDER_DEFINES_SVH
`define TRUNCATED_TIME_OF_DAY_REBUILDER_DEFINES_SVH

// property checked only while out of reset
`define TTOD_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define TTOD_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/ttod_pkg.sv
// shared types and constants of the time of day rebuilder
`default_nettype none

package ttod_pkg;

   localparam int unsigned SAC_W   = 8;
   localparam int unsigned SIC_W   = 8;
   localparam int unsigned FULL_W  = 24;
   localparam int unsigned TRUNC_W = 16;
   localparam int unsigned HIGH_W  = 8;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned TIME_W  = 26;
   localparam int unsigned ENTRY_W = SAC_W + SIC_W + HIGH_W + TRUNC_W;

   localparam logic [0:0] FUNC_STORE   = 1'b0;
   localparam logic [0:0] FUNC_REBUILD = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd1;
   localparam logic [STAT_W-1:0] ST_WINDOW  = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

   localparam logic [TRUNC_W-1:0] TRACK_WINDOW_RESET = 16'd2048;
   localparam logic [TRUNC_W-1:0] ROLL_LOW           = 16'hB800;
   localparam logic [TRUNC_W-1:0] ROLL_HIGH          = 16'hC000;
   localparam logic [HIGH_W-1:0]  ROLL_HOUR          = 8'hA8;
   localparam logic [TRUNC_W-1:0] WRAP_LIMIT         = 16'hF800;

   typedef struct packed {
      logic start;   // latch request and begin table scan
      logic exec;    // apply update and load result
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } sts_type;

endpackage

`default_nettype wire

// File: design/ttod_ctrl.sv
// controller state machine of the time of day rebuilder
`default_nettype none
`include "truncated_time_of_day_rebuilder_defines.svh"

module ttod_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire ttod_pkg::sts_type sts,
   output ttod_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_EXEC = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      out_free;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      state_in  = state_ff;
      cmd.start = 1'b0;
      cmd.exec  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // hold the result until the output register can take it
            if (out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.exec) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   `TTOD_ASSERT(a_exec_needs_room, clock, reset, cmd.exec |-> out_free, "result overwrote pending")
   `TTOD_ASSERT(a_exec_shows_rsp, clock, reset, cmd.exec |=> rsp_tvalid, "result not presented")
   `TTOD_ASSERT(a_accept_scans, clock, reset, (req_tvalid && req_tready) |=> (state_ff == S_SCAN && !req_tready), "accept did not start a scan")

endmodule

`default_nettype wire

// File: design/ttod_dp.sv
// datapath of the time of day rebuilder: radar table, scan and rebuild arithmetic
`default_nettype none
`include "truncated_time_of_day_rebuilder_defines.svh"

module ttod_dp #(
   parameter int unsigned RADAR_SLOTS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [ttod_pkg::TRUNC_W-1:0]       csr_wr_data,
   input  wire logic                               req_func,
   input  wire logic [ttod_pkg::SAC_W-1:0]         req_sac,
   input  wire logic [ttod_pkg::SIC_W-1:0]         req_sic,
   input  wire logic [ttod_pkg::FULL_W-1:0]        req_full,
   input  wire logic [ttod_pkg::TRUNC_W-1:0]       req_trunc,
   input  wire ttod_pkg::cmd_type                  cmd,
   output ttod_pkg::sts_type                       sts,
   output logic [ttod_pkg::STAT_W-1:0]             rsp_status,
   output logic [ttod_pkg::TIME_W-1:0]             rsp_time
);

   localparam int unsigned IDX_W = (RADAR_SLOTS > 1) ? $clog2(RADAR_SLOTS) : 1;
   localparam int unsigned CNT_W = $clog2(RADAR_SLOTS + 1);
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(RADAR_SLOTS);
   localparam int unsigned HI_W = ttod_pkg::TIME_W - ttod_pkg::TRUNC_W;

   // table entry: {sac, sic, high, last}
   logic [ttod_pkg::ENTRY_W-1:0] mem [RADAR_SLOTS];
   logic [RADAR_SLOTS-1:0]       vld_ff;

   logic [ttod_pkg::TRUNC_W-1:0] window_ff;

   logic                         func_ff;
   logic [ttod_pkg::SAC_W-1:0]   sac_ff;
   logic [ttod_pkg::SIC_W-1:0]   sic_ff;
   logic [ttod_pkg::FULL_W-1:0]  full_ff;
   logic [ttod_pkg::TRUNC_W-1:0] trunc_ff;

   logic [CNT_W-1:0]             scan_cnt_ff;
   logic                         issue;
   logic                         rd_vld_ff;
   logic [IDX_W-1:0]             rd_idx_ff;
   logic [ttod_pkg::ENTRY_W-1:0] rd_data_ff;

   logic                         hit_ff;
   logic [IDX_W-1:0]             hit_idx_ff;
   logic [ttod_pkg::HIGH_W-1:0]  hit_high_ff;
   logic [ttod_pkg::TRUNC_W-1:0] hit_last_ff;
   logic                         free_ff;
   logic [IDX_W-1:0]             free_idx_ff;
   logic                         match;

   logic [ttod_pkg::STAT_W-1:0]  rsp_status_ff, status_in;
   logic [ttod_pkg::TIME_W-1:0]  rsp_time_ff, time_in;

   logic [ttod_pkg::TRUNC_W:0]   diff_qp;
   logic [ttod_pkg::TRUNC_W-1:0] diff_pq;
   logic [ttod_pkg::TRUNC_W-1:0] stamp_gap;
   logic                         q_gt_p;
   logic [HI_W-1:0]              high_ext;
   logic [HI_W-1:0]              high_dec;
   logic [HI_W-1:0]              high_inc;

   logic                         wr_en;
   logic [IDX_W-1:0]             wr_idx;
   logic [ttod_pkg::ENTRY_W-1:0] wr_data;
   logic                         set_vld;

   assign issue = (scan_cnt_ff != SCAN_END) && !cmd.start;
   assign sts.scan_done = (scan_cnt_ff == SCAN_END) && !rd_vld_ff;

   assign match = rd_vld_ff && vld_ff[rd_idx_ff]
                  && (rd_data_ff[ttod_pkg::ENTRY_W-1 -: ttod_pkg::SAC_W] == sac_ff)
                  && (rd_data_ff[ttod_pkg::ENTRY_W-ttod_pkg::SAC_W-1 -: ttod_pkg::SIC_W]
                      == sic_ff);

   // distance between the new stamp and the stored one
   assign diff_qp   = {1'b0, trunc_ff} - {1'b0, hit_last_ff};
   assign diff_pq   = hit_last_ff - trunc_ff;
   assign stamp_gap = diff_qp[ttod_pkg::TRUNC_W] ? diff_pq : diff_qp[ttod_pkg::TRUNC_W-1:0];
   assign q_gt_p    = !diff_qp[ttod_pkg::TRUNC_W] && (diff_qp != '0);
   assign high_ext  = {{(HI_W-ttod_pkg::HIGH_W){1'b0}}, hit_high_ff};
   assign high_dec  = high_ext - HI_W'(1);
   assign high_inc  = high_ext + HI_W'(1);

   always_comb begin
      status_in = ttod_pkg::ST_OK;
      time_in   = '0;
      wr_en     = 1'b0;
      wr_idx    = hit_idx_ff;
      wr_data   = {sac_ff, sic_ff, full_ff};
      set_vld   = 1'b0;
      if (func_ff == ttod_pkg::FUNC_STORE) begin
         if (hit_ff) begin
            wr_en = 1'b1;
         end else if (free_ff) begin
            wr_en   = 1'b1;
            wr_idx  = free_idx_ff;
            set_vld = 1'b1;
         end else begin
            status_in = ttod_pkg::ST_FULL;
         end
      end else if (!hit_ff) begin
         status_in = ttod_pkg::ST_UNKNOWN;
      end else if (stamp_gap <= window_ff) begin
         wr_en   = 1'b1;
         wr_data = {sac_ff, sic_ff, hit_high_ff, trunc_ff};
         time_in = {high_ext, trunc_ff};
      end else if (stamp_gap > ttod_pkg::ROLL_LOW && stamp_gap <= ttod_pkg::ROLL_HIGH
                   && hit_high_ff == ttod_pkg::ROLL_HOUR) begin
         // midnight rollover
         time_in = {{HI_W{1'b0}}, trunc_ff};
      end else if (stamp_gap > ttod_pkg::WRAP_LIMIT) begin
         // 16-bit stamp wrapped one way or the other
         time_in = q_gt_p ? {high_dec, trunc_ff} : {high_inc, trunc_ff};
      end else begin
         status_in = ttod_pkg::ST_WINDOW;
      end
      if (!cmd.exec) begin
         wr_en   = 1'b0;
         set_vld = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= mem[scan_cnt_ff[IDX_W-1:0]];
      end
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         func_ff  <= req_func;
         sac_ff   <= req_sac;
         sic_ff   <= req_sic;
         full_ff  <= req_full;
         trunc_ff <= req_trunc;
      end
      if (issue) begin
         rd_idx_ff <= scan_cnt_ff[IDX_W-1:0];
      end
      if (match && !hit_ff) begin
         hit_idx_ff  <= rd_idx_ff;
         hit_high_ff <= rd_data_ff[ttod_pkg::TRUNC_W +: ttod_pkg::HIGH_W];
         hit_last_ff <= rd_data_ff[ttod_pkg::TRUNC_W-1:0];
      end
      if (rd_vld_ff && !vld_ff[rd_idx_ff] && !free_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
      if (cmd.exec) begin
         rsp_status_ff <= status_in;
         rsp_time_ff   <= time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         window_ff   <= ttod_pkg::TRACK_WINDOW_RESET;
         scan_cnt_ff <= SCAN_END;
         rd_vld_ff   <= 1'b0;
         hit_ff      <= 1'b0;
         free_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
         end
         if (set_vld) begin
            vld_ff[wr_idx] <= 1'b1;
         end
         rd_vld_ff <= issue;
         if (cmd.start) begin
            scan_cnt_ff <= '0;
            hit_ff      <= 1'b0;
            free_ff     <= 1'b0;
         end else begin
            if (issue) begin
               scan_cnt_ff <= scan_cnt_ff + CNT_W'(1);
            end
            if (match) begin
               hit_ff <= 1'b1;
            end
            if (rd_vld_ff && !vld_ff[rd_idx_ff]) begin
               free_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_time   = rsp_time_ff;

   `TTOD_ASSERT(a_hit_is_valid, clock, reset, hit_ff |-> vld_ff[hit_idx_ff], "hit on an invalid entry")
   `TTOD_ASSERT(a_free_is_free, clock, reset, (cmd.exec && free_ff) |-> !vld_ff[free_idx_ff], "free slot already in use")
   `TTOD_ASSERT(a_scan_bounded, clock, reset, scan_cnt_ff <= SCAN_END, "scan counter overran the table")

endmodule

`default_nettype wire

// File: design/truncated_time_of_day_rebuilder.sv
// after acceptance the request is latched, the table scanned and the result register loaded
// the table scan reads one entry per cycle from a single-port memory
// one request is in work at a time; a new one is taken only once the previous result is loaded
// the result register lets a new request enter while the previous result waits
// synchronous active-high reset marks every table entry unused and restores the window to 2048
`default_nettype none

module truncated_time_of_day_rebuilder #(
   parameter int unsigned RADAR_SLOTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,   // track_window
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,     // radar_sac, radar_sic, full_time, truncated_time
   input  wire logic        req_tuser,     // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata      // status, rebuilt_time, zero fill
);

   ttod_pkg::cmd_type cmd;
   ttod_pkg::sts_type sts;
   logic [ttod_pkg::STAT_W-1:0] rsp_status;
   logic [ttod_pkg::TIME_W-1:0] rsp_time;

   ttod_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ttod_dp #(
      .RADAR_SLOTS (RADAR_SLOTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_func    (req_tuser),
      .req_sac     (req_tdata[7:0]),
      .req_sic     (req_tdata[15:8]),
      .req_full    (req_tdata[39:16]),
      .req_trunc   (req_tdata[55:40]),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_status  (rsp_status),
      .rsp_time    (rsp_time)
   );

   assign rsp_tdata = {4'b0000, rsp_time, rsp_status};

endmodule

`default_nettype wire

// File: tb/sv/truncated_time_of_day_rebuilder_checker.sv
// checker that predicts the rebuilder's results and compares them with the response channel
module truncated_time_of_day_rebuilder_checker
   import ttod_pkg::*;
#(
   parameter int unsigned RADAR_SLOTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [55:0] req_tdata,     // radar_sac, radar_sic, full_time, truncated_time
   input  wire logic        req_tuser,     // func
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,     // status, rebuilt_time, zero fill
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // status sits in the low bits, as on rsp_tdata
   typedef struct packed {
      logic [TIME_W-1:0] rebuilt_time;
      logic [STAT_W-1:0] status;
   } tod_result_type;

   logic               radar_valid [RADAR_SLOTS];
   logic [SAC_W-1:0]   radar_sac   [RADAR_SLOTS];
   logic [SIC_W-1:0]   radar_sic   [RADAR_SLOTS];
   logic [HIGH_W-1:0]  radar_high  [RADAR_SLOTS];
   logic [TRUNC_W-1:0] radar_last  [RADAR_SLOTS];
   logic [TRUNC_W-1:0] track_window;
   tod_result_type     expected_times [$];

   function automatic tod_result_type rebuild_time_of_day(input logic func,
                                                          input logic [SAC_W-1:0] sac,
                                                          input logic [SIC_W-1:0] sic,
                                                          input logic [FULL_W-1:0] full,
                                                          input logic [TRUNC_W-1:0] stamp);
      int slot;
      int last;
      int diff;
      int hour;
      int rebuilt;
      tod_result_type r;
      slot = -1;
      rebuilt = 0;
      r.status = ST_OK;
      for (int i = 0; i < RADAR_SLOTS; i++)
         if (slot < 0 && radar_valid[i] && radar_sac[i] == sac && radar_sic[i] == sic)
            slot = i;
      if (func == FUNC_STORE) begin
         if (slot < 0) begin
            for (int i = 0; i < RADAR_SLOTS; i++)
               if (slot < 0 && !radar_valid[i])
                  slot = i;
            if (slot >= 0) begin
               radar_valid[slot] = 1'b1;
               radar_sac[slot]   = sac;
               radar_sic[slot]   = sic;
            end
         end
         if (slot < 0) begin
            r.status = ST_FULL;
         end else begin
            radar_high[slot] = full[23:16];
            radar_last[slot] = full[15:0];
         end
      end else if (slot < 0) begin
         r.status = ST_UNKNOWN;
      end else begin
         last = int'(radar_last[slot]);
         hour = int'(radar_high[slot]);
         diff = (int'(stamp) >= last) ? int'(stamp) - last : last - int'(stamp);
         // tracking wins over rollover and wrap, so a wide window hides them
         if (diff <= int'(track_window)) begin
            radar_last[slot] = stamp;
            rebuilt = hour * 65536 + int'(stamp);
         end else if (diff > int'(ROLL_LOW) && diff <= int'(ROLL_HIGH) &&
                      radar_high[slot] == ROLL_HOUR) begin
            rebuilt = int'(stamp);
         end else if (diff > int'(WRAP_LIMIT)) begin
            if (int'(stamp) > last)
               rebuilt = (hour - 1) * 65536 + int'(stamp);
            else
               rebuilt = (hour + 1) * 65536 + int'(stamp);
         end else begin
            r.status = ST_WINDOW;
         end
      end
      r.rebuilt_time = rebuilt[TIME_W-1:0];
      return r;
   endfunction

   initial fail_count = 0;

   always @(posedge clock) begin
      tod_result_type got;
      tod_result_type want;
      if (reset) begin
         for (int i = 0; i < RADAR_SLOTS; i++) begin
            radar_valid[i] = 1'b0;
            radar_sac[i]   = '0;
            radar_sic[i]   = '0;
            radar_high[i]  = '0;
            radar_last[i]  = '0;
         end
         track_window = TRACK_WINDOW_RESET;
         expected_times.delete();
      end else begin
         if (csr_wr_en)
            track_window = csr_wr_data;
         // compare before predicting, so a result never meets its own request
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[TIME_W+STAT_W-1:0];
            if (expected_times.size() == 0) begin
               $display("%0t: unexpected result, actual status %0d time %h",
                        $realtime, got.status, got.rebuilt_time);
               fail_count++;
            end else begin
               want = expected_times.pop_front();
               if (got.status != want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $realtime, want.status, got.status);
                  fail_count++;
               end
               if (got.rebuilt_time != want.rebuilt_time) begin
                  $display("%0t: rebuilt_time expected %h actual %h",
                           $realtime, want.rebuilt_time, got.rebuilt_time);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_times.push_back(rebuild_time_of_day(req_tuser, req_tdata[7:0],
                                                         req_tdata[15:8], req_tdata[39:16],
                                                         req_tdata[55:40]));
      end
      pending_count = expected_times.size();
   end

endmodule

// File: tb/sv/tb_truncated_time_of_day_rebuilder.sv
// testbench top: drives window writes, radar store and rebuild requests and gives the verdict
module tb_truncated_time_of_day_rebuilder;
   timeunit 1ns;
   timeprecision 1ps;
   import ttod_pkg::*;

   localparam int POOL_SIZE        = 20;
   localparam int SETTLE_CYCLES    = 30;
   localparam int RANDOM_PER_PHASE = 310;
   localparam int CYCLE_LIMIT      = 400000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata   = '0;     // radar_sac, radar_sic, full_time, truncated_time
   logic        req_tuser   = 1'b0;   // func
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;            // status, rebuilt_time, zero fill
   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;
   bit          no_gaps     = 1'b0;
   logic [15:0] cur_window  = TRACK_WINDOW_RESET;

   // radars that the random part keeps talking to; more than the table holds
   logic [7:0]  pool_sac  [POOL_SIZE];
   logic [7:0]  pool_sic  [POOL_SIZE];
   logic [15:0] pool_last [POOL_SIZE];

   truncated_time_of_day_rebuilder i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   truncated_time_of_day_rebuilder_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= no_gaps || ($urandom_range(0, 99) >= 13);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_truncated_time_of_day_rebuilder NOT OK");
         $finish;
      end
   end

   task automatic send_request(input logic func, input logic [7:0] sac,
                               input logic [7:0] sic, input logic [23:0] full,
                               input logic [15:0] stamp);
      if (!no_gaps && $urandom_range(0, 99) < 13) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {stamp, full, sic, sac};
      do @(posedge clock); while (!req_tready);
   endtask

   // wait until every result is back, then let the block settle
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [15:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_window   = value;
   endtask

   task automatic send_random_request();
      int pick;
      int k;
      int kind;
      int off;
      logic [15:0] p;
      logic [15:0] q;
      logic [23:0] full;
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, POOL_SIZE - 1);
      full = 24'($urandom);
      q    = 16'($urandom);
      if (pick < 8) begin
         // noise: mostly unknown radars, an odd store that may take a free entry
         send_request(($urandom_range(0, 7) != 0) ? FUNC_REBUILD : FUNC_STORE,
                      8'($urandom), 8'($urandom), full, q);
      end else if (pick < 30) begin
         kind = $urandom_range(0, 9);
         if (kind < 2)
            full[23:16] = ROLL_HOUR;
         else if (kind == 2)
            full[23:16] = 8'h00;
         else if (kind == 3)
            full[23:16] = 8'hFF;
         // stamps near the ends of the range make wraps reachable
         kind = $urandom_range(0, 9);
         if (kind < 2)
            full[15:0] = 16'($urandom_range(0, 16'h07FF));
         else if (kind < 4)
            full[15:0] = 16'($urandom_range(16'hF800, 16'hFFFF));
         pool_last[k] = full[15:0];
         send_request(FUNC_STORE, pool_sac[k], pool_sic[k], full, q);
      end else begin
         p    = pool_last[k];
         kind = $urandom_range(0, 19);
         if (kind < 10) begin
            off = $urandom_range(0, (cur_window > 16'd4096) ? 4096 : int'(cur_window));
            if ($urandom_range(0, 9) == 0)
               off = int'(cur_window);
            q = $urandom_range(0, 1) ? 16'(int'(p) + off) : 16'(int'(p) - off);
            pool_last[k] = q;
         end else if (kind < 13) begin
            off = $urandom_range(16'hB7F0, 16'hC010);
            q = (int'(p) >= off) ? 16'(int'(p) - off) : 16'(int'(p) + off);
         end else if (kind < 16) begin
            off = $urandom_range(16'hF7F0, 16'hFFFF);
            q = (int'(p) >= off) ? 16'(int'(p) - off) : 16'(int'(p) + off);
         end
         send_request(FUNC_REBUILD, pool_sac[k], pool_sic[k], full, q);
      end
   endtask

   initial begin
      logic [15:0] windows [5];
      pool_sac[0] = 8'h00;  pool_sic[0] = 8'h00;
      pool_sac[1] = 8'hFF;  pool_sic[1] = 8'hFF;
      pool_sac[2] = 8'h00;  pool_sic[2] = 8'hFF;
      pool_sac[3] = 8'hFF;  pool_sic[3] = 8'h00;
      for (int i = 4; i < POOL_SIZE; i++) begin
         pool_sac[i]  = 8'($urandom);
         pool_sic[i]  = 8'($urandom);
         pool_last[i] = 16'($urandom);
      end
      windows = '{16'd0, 16'hFFFF, 16'd300, 16'(($urandom)), TRACK_WINDOW_RESET};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part, window at its reset value
      send_request(FUNC_REBUILD, 8'h00, 8'h00, 24'($urandom), 16'h1234); // not stored yet
      send_request(FUNC_STORE,   8'h00, 8'h00, 24'hA8F000, 16'($urandom));
      send_request(FUNC_REBUILD, 8'h00, 8'h00, 24'($urandom), 16'hF800); // tracking at the edge
      send_request(FUNC_REBUILD, 8'h00, 8'h00, 24'($urandom), 16'hEFFF); // one past the window
      send_request(FUNC_REBUILD, 8'h00, 8'h00, 24'($urandom), 16'h3800); // midnight rollover
      send_request(FUNC_REBUILD, 8'h00, 8'h00, 24'($urandom), 16'h4000); // rollover lower bound
      send_request(FUNC_REBUILD, 8'h00, 8'h00, 24'($urandom), 16'h37FF); // past rollover band
      send_request(FUNC_STORE,   8'hFF, 8'hFF, 24'h000100, 16'($urandom));
      send_request(FUNC_REBUILD, 8'hFF, 8'hFF, 24'($urandom), 16'hFF80); // wrap back below zero
      send_request(FUNC_STORE,   8'hFF, 8'hFF, 24'h000000, 16'($urandom));
      send_request(FUNC_REBUILD, 8'hFF, 8'hFF, 24'($urandom), 16'hFFFF);
      send_request(FUNC_STORE,   8'hFF, 8'hFF, 24'hFFFF80, 16'($urandom));
      send_request(FUNC_REBUILD, 8'hFF, 8'hFF, 24'($urandom), 16'h0010); // wrap forward
      send_request(FUNC_STORE,   8'h00, 8'hFF, 24'hFFFFFF, 16'($urandom));
      send_request(FUNC_REBUILD, 8'h00, 8'hFF, 24'($urandom), 16'hFFFF);
      send_request(FUNC_REBUILD, 8'h00, 8'hFF, 24'($urandom), 16'h0000); // wrap past top hour
      send_request(FUNC_STORE,   8'hFF, 8'h00, 24'hA80100, 16'($urandom));
      send_request(FUNC_REBUILD, 8'hFF, 8'h00, 24'($urandom), 16'hC100); // rollover upward
      send_request(FUNC_REBUILD, 8'h00, 8'h01, 24'($urandom), 16'h0100); // sac alone matches
      send_request(FUNC_REBUILD, 8'h01, 8'hFF, 24'($urandom), 16'hFFFF); // sic alone matches
      send_request(FUNC_STORE,   8'h00, 8'h00, 24'h123456, 16'($urandom)); // update in place
      send_request(FUNC_REBUILD, 8'h00, 8'h00, 24'($urandom), 16'h3456);
      pool_last[0] = 16'h3456;
      pool_last[1] = 16'hFF80;
      pool_last[2] = 16'hFFFF;
      pool_last[3] = 16'h0100;

      repeat (RANDOM_PER_PHASE) send_random_request();
      foreach (windows[i]) begin
         write_window(windows[i]);
         no_gaps = (windows[i] == 16'd300);
         repeat (RANDOM_PER_PHASE) send_random_request();
      end

      drain_results();
      if (fail_count == 0)
         $display("tb_truncated_time_of_day_rebuilder OK");
      else
         $display("tb_truncated_time_of_day_rebuilder NOT OK");
      $finish;
   end

endmodule

// File: sim.f
+incdir+design
design/ttod_pkg.sv
design/ttod_ctrl.sv
design/ttod_dp.sv
design/truncated_time_of_day_rebuilder.sv
tb/sv/truncated_time_of_day_rebuilder_checker.sv
tb/sv/tb_truncated_time_of_day_rebuilder.sv
